[rtl/core/gsd_pkg.sv]
package gsd_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STD_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DIR      = 2'd3;

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] STD_PERIOD_RST     = 16'd640;
    localparam logic [CFG_DATA_W-1:0] REDUCED_PERIOD_RST = 16'd12800;
    localparam logic [CFG_DATA_W-1:0] RAMP_STEP_RST      = 16'd1;
    localparam logic                  CLOSE_DIR_RST      = 1'b0;

    // configuration bundle
    typedef struct packed {
        logic [CFG_DATA_W-1:0] std_period;
        logic [CFG_DATA_W-1:0] reduced_period;
        logic [CFG_DATA_W-1:0] ramp_step;
        logic                  close_dir_level;
    } gsd_cfg_t;

    // one input item
    typedef struct packed {
        logic end_close_hit;
        logic end_open_hit;
        logic close_button_edge;
        logic open_button_edge;
    } gsd_item_t;

    // one result item
    typedef struct packed {
        logic at_min_speed;
        logic compare_event;
        logic led_close;
        logic led_open;
        logic motor_enable;
        logic dir_level;
        logic step_level;
    } gsd_result_t;

endpackage

[rtl/core/gsd_cfg_regs.sv]
module gsd_cfg_regs
    import gsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output gsd_cfg_t              cfg
);

    gsd_cfg_t cfg_reg;
    gsd_cfg_t cfg_next;

    // decode of a register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_STD_PERIOD:     cfg_next.std_period      = cfg_wdata;
                CFG_REDUCED_PERIOD: cfg_next.reduced_period  = cfg_wdata;
                CFG_RAMP_STEP:      cfg_next.ramp_step       = cfg_wdata;
                CFG_CLOSE_DIR:      cfg_next.close_dir_level = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.std_period      <= STD_PERIOD_RST;
            cfg_reg.reduced_period  <= REDUCED_PERIOD_RST;
            cfg_reg.ramp_step       <= RAMP_STEP_RST;
            cfg_reg.close_dir_level <= CLOSE_DIR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/gsd_motion.sv]
module gsd_motion
    import gsd_pkg::*;
#(
    parameter int PERIOD_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  gsd_cfg_t    cfg,
    input  logic        fire,
    input  gsd_item_t   item,
    output gsd_result_t res
);

    localparam int SUM_W = ((PERIOD_WIDTH > CFG_DATA_W) ? PERIOD_WIDTH : CFG_DATA_W) + 1;

    logic [PERIOD_WIDTH-1:0] tick_counter_reg;
    logic [PERIOD_WIDTH-1:0] tick_counter_next;
    logic [PERIOD_WIDTH-1:0] period_reg;
    logic [PERIOD_WIDTH-1:0] period_next;
    logic                    moving_open_reg;
    logic                    moving_open_next;
    logic                    moving_close_reg;
    logic                    moving_close_next;
    logic                    slow_mode_reg;
    logic                    slow_mode_next;
    logic                    step_reg;
    logic                    step_next;
    logic                    dir_reg;
    logic                    dir_next;
    logic                    enable_reg;
    logic                    enable_next;
    logic [1:0]              lamp_reg;
    logic [1:0]              lamp_next;

    logic                    mo_btn;
    logic                    mc_btn;
    logic                    slow_btn;
    logic                    event_hit;
    logic                    stop_hit;
    logic [PERIOD_WIDTH-1:0] std_p;
    logic [PERIOD_WIDTH-1:0] red_p;
    logic [SUM_W-1:0]        ramp_sum;

    assign std_p    = PERIOD_WIDTH'(cfg.std_period);
    assign red_p    = PERIOD_WIDTH'(cfg.reduced_period);
    assign ramp_sum = SUM_W'(period_reg) + SUM_W'(cfg.ramp_step);
    assign stop_hit = item.end_open_hit | item.end_close_hit;
    assign event_hit = (tick_counter_reg == period_reg);

    // button events, first button then second
    always_comb
    begin
        mo_btn   = moving_open_reg;
        mc_btn   = moving_close_reg;
        slow_btn = slow_mode_reg;
        if (item.open_button_edge)
        begin
            if (mo_btn)
            begin
                slow_btn = 1'b1;
            end
            else
            begin
                mc_btn = 1'b1;
                mo_btn = 1'b0;
            end
        end
        if (item.close_button_edge)
        begin
            if (mc_btn)
            begin
                slow_btn = 1'b1;
            end
            else
            begin
                mc_btn = 1'b0;
                mo_btn = 1'b1;
            end
        end
    end

    // tick counter and step logic on compare match
    always_comb
    begin
        moving_open_next  = mo_btn;
        moving_close_next = mc_btn;
        slow_mode_next    = slow_btn;
        tick_counter_next = tick_counter_reg + 1'b1;
        period_next       = period_reg;
        step_next         = step_reg;
        dir_next          = dir_reg;
        enable_next       = enable_reg;
        lamp_next         = lamp_reg;
        if (event_hit)
        begin
            tick_counter_next = '0;
            if (stop_hit)
            begin
                enable_next       = 1'b0;
                moving_open_next  = 1'b0;
                moving_close_next = 1'b0;
                slow_mode_next    = 1'b0;
                lamp_next         = 2'b00;
            end
            else
            begin
                if (mo_btn)
                begin
                    dir_next     = ~cfg.close_dir_level;
                    enable_next  = 1'b1;
                    step_next    = ~step_reg;
                    lamp_next[0] = 1'b1;
                end
                else if (mc_btn)
                begin
                    dir_next     = cfg.close_dir_level;
                    enable_next  = 1'b1;
                    step_next    = ~step_reg;
                    lamp_next[1] = 1'b1;
                end
                if (slow_btn)
                begin
                    if (ramp_sum < SUM_W'(red_p))
                    begin
                        period_next = ramp_sum[PERIOD_WIDTH-1:0];
                    end
                    else
                    begin
                        period_next = red_p;
                    end
                end
                else
                begin
                    period_next = std_p;
                end
            end
        end
    end

    // result of this item, state after the tick
    always_comb
    begin
        res.step_level    = step_next;
        res.dir_level     = dir_next;
        res.motor_enable  = enable_next;
        res.led_open      = lamp_next[0];
        res.led_close     = lamp_next[1];
        res.compare_event = event_hit;
        res.at_min_speed  = (period_next == red_p);
    end

    // drive state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_counter_reg <= '0;
            period_reg       <= PERIOD_WIDTH'(STD_PERIOD_RST);
            moving_open_reg  <= 1'b0;
            moving_close_reg <= 1'b0;
            slow_mode_reg    <= 1'b0;
            step_reg         <= 1'b0;
            dir_reg          <= 1'b0;
            enable_reg       <= 1'b0;
            lamp_reg         <= 2'b00;
        end
        else if (fire)
        begin
            tick_counter_reg <= tick_counter_next;
            period_reg       <= period_next;
            moving_open_reg  <= moving_open_next;
            moving_close_reg <= moving_close_next;
            slow_mode_reg    <= slow_mode_next;
            step_reg         <= step_next;
            dir_reg          <= dir_next;
            enable_reg       <= enable_next;
            lamp_reg         <= lamp_next;
        end
    end

    // never moving both ways
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        !(moving_open_reg && moving_close_reg))
        else $error("moving open and close at once");

    // end stop on a compare stops the driver
    a_stop_disables: assert property (@(posedge clk) disable iff (!rst_n)
        fire && event_hit && stop_hit |=> !enable_reg && !slow_mode_reg && lamp_reg == 2'b00)
        else $error("end stop did not stop the driver");

    // step level toggles only on a compare
    a_step_on_event: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !event_hit |=> $stable(step_reg) && $stable(period_reg))
        else $error("step or period changed without compare");

endmodule

[rtl/core/gate_stepper_drive_with_slowdown_core.sv]
// Stepper drive for a gate with a slow-down ramp.
// Input stream: one item per timer tick, carrying the two button falling-edge
// flags and the two end-stop levels. Output stream: one item per input item
// with the step, direction, enable and lamp levels after that tick, plus the
// compare-match flag and the at-minimum-speed flag.
// Configuration: write cfg_we with cfg_addr/cfg_wdata while the block is idle;
// index 0 standard period, 1 reduced period, 2 ramp step, 3 closing direction.
// Flow: an item taken is held in the input register; its result is loaded
// into the output register when that register is empty or being read, and is
// shown from then on. Throughput: one item per cycle while m_tready is high;
// the whole tick update is one pass of counter compare, ramp add/compare and
// selection between the two registers.
// Reset: config registers take their defaults (640, 12800, 1, 0), the tick
// counter clears, the period loads 640, the motor is off and no item is held.
// Stall: while m_tready is low the result stays in the output register, one
// more item waits in the input register, and s_tready then drops.
module gate_stepper_drive_with_slowdown_core
    import gsd_pkg::*;
#(
    parameter int PERIOD_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // open_button_edge, close_button_edge, end_open_hit, end_close_hit, zero fill
    input  logic [7:0]            s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // step_level, dir_level, motor_enable, led_open, led_close, compare_event,
    // at_min_speed, zero fill
    output logic [7:0]            m_tdata
);

    gsd_cfg_t    cfg;
    gsd_item_t   item_reg;
    gsd_item_t   item_next;
    gsd_result_t res;
    gsd_result_t result_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        advance;
    logic        s_take;

    gsd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gsd_motion #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_motion
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .item  (item_reg),
        .res   (res)
    );

    // handshake between input register and output register
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        item_next.open_button_edge  = s_tdata[0];
        item_next.close_button_edge = s_tdata[1];
        item_next.end_open_hit      = s_tdata[2];
        item_next.end_close_hit     = s_tdata[3];
        in_valid_next  = s_take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            result_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       result_reg.at_min_speed,
                       result_reg.compare_event,
                       result_reg.led_close,
                       result_reg.led_open,
                       result_reg.motor_enable,
                       result_reg.dir_level,
                       result_reg.step_level};

    // a held item is never dropped
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item lost");

    // an advanced item always shows up at the output
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result missing after advance");

    // a stalled result item stays put
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

endmodule

[test/gsd_drive_check.sv]
`timescale 1ns / 1ps

module gsd_drive_check
    import gsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // open_button_edge, close_button_edge, end_open_hit, end_close_hit, zero fill
    input  logic [7:0]            s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // step_level, dir_level, motor_enable, led_open, led_close, compare_event,
    // at_min_speed, zero fill
    input  logic [7:0]            m_tdata,
    output int                    fail_count,
    output int                    pending_results,
    output int                    results_checked,
    output int                    compare_hits
);

    localparam int PW = 16;

    // shadow of the configuration registers
    gsd_cfg_t cfg_copy;

    // shadow of the drive state
    logic [PW-1:0] tick_cnt;
    logic [PW-1:0] cur_period;
    logic          go_open;
    logic          go_close;
    logic          slowing;
    logic          step_q;
    logic          dir_q;
    logic          enable_q;
    logic [1:0]    lamps;

    // predicted outputs, oldest first
    gsd_result_t drive_outputs_q[$];

    // advance the drive by one timer tick and return the outputs after it
    task automatic tick_drive(input gsd_item_t it, output gsd_result_t res);
        logic          stop_hit;
        logic          matched;
        logic [PW:0]   grown;
        logic [PW-1:0] floor_p;
        begin
            stop_hit = it.end_open_hit | it.end_close_hit;
            floor_p  = cfg_copy.reduced_period;

            // button events first, the second one sees the first
            if (it.open_button_edge) begin
                if (go_open) begin
                    slowing = 1'b1;
                end
                else begin
                    go_close = 1'b1;
                    go_open  = 1'b0;
                end
            end
            if (it.close_button_edge) begin
                if (go_close) begin
                    slowing = 1'b1;
                end
                else begin
                    go_close = 1'b0;
                    go_open  = 1'b1;
                end
            end

            // compare is tested before counting
            matched = (tick_cnt == cur_period);
            if (matched) begin
                tick_cnt = '0;
                if (stop_hit) begin
                    // end stop: motor off, step, direction and period kept
                    enable_q = 1'b0;
                    go_open  = 1'b0;
                    go_close = 1'b0;
                    slowing  = 1'b0;
                    lamps    = 2'b00;
                end
                else begin
                    if (go_open) begin
                        dir_q    = ~cfg_copy.close_dir_level;
                        enable_q = 1'b1;
                        step_q   = ~step_q;
                        lamps[0] = 1'b1;
                    end
                    else if (go_close) begin
                        dir_q    = cfg_copy.close_dir_level;
                        enable_q = 1'b1;
                        step_q   = ~step_q;
                        lamps[1] = 1'b1;
                    end
                    // ramp toward the reduced period, or back to full speed
                    if (slowing) begin
                        grown = {1'b0, cur_period} + {1'b0, cfg_copy.ramp_step};
                        if (grown < {1'b0, floor_p})
                            cur_period = grown[PW-1:0];
                        else
                            cur_period = floor_p;
                    end
                    else begin
                        cur_period = cfg_copy.std_period;
                    end
                end
            end
            else begin
                tick_cnt = tick_cnt + 1'b1;
            end

            res.step_level    = step_q;
            res.dir_level     = dir_q;
            res.motor_enable  = enable_q;
            res.led_open      = lamps[0];
            res.led_close     = lamps[1];
            res.compare_event = matched;
            res.at_min_speed  = (cur_period == floor_p);
        end
    endtask

    task automatic check_bit(input string name, input logic want, input logic got);
        begin
            if (got !== want) begin
                $error("%s: expected %0b, got %0b", name, want, got);
                fail_count++;
            end
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n) begin : watch
        gsd_result_t want;
        gsd_result_t got;
        if (!rst_n) begin
            cfg_copy.std_period      = STD_PERIOD_RST;
            cfg_copy.reduced_period  = REDUCED_PERIOD_RST;
            cfg_copy.ramp_step       = RAMP_STEP_RST;
            cfg_copy.close_dir_level = CLOSE_DIR_RST;
            tick_cnt        = '0;
            cur_period      = STD_PERIOD_RST;
            go_open         = 1'b0;
            go_close        = 1'b0;
            slowing         = 1'b0;
            step_q          = 1'b0;
            dir_q           = 1'b0;
            enable_q        = 1'b0;
            lamps           = 2'b00;
            drive_outputs_q.delete();
            fail_count      = 0;
            pending_results = 0;
            results_checked = 0;
            compare_hits    = 0;
        end
        else begin
            // register writes
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_STD_PERIOD:     cfg_copy.std_period      = cfg_wdata;
                    CFG_REDUCED_PERIOD: cfg_copy.reduced_period  = cfg_wdata;
                    CFG_RAMP_STEP:      cfg_copy.ramp_step       = cfg_wdata;
                    CFG_CLOSE_DIR:      cfg_copy.close_dir_level = cfg_wdata[0];
                    default: ;
                endcase
            end

            // compare each result item with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = gsd_result_t'(m_tdata[6:0]);
                if (drive_outputs_q.size() == 0) begin
                    $error("result item with nothing pending: %b", m_tdata);
                    fail_count++;
                end
                else begin
                    want = drive_outputs_q.pop_front();
                    check_bit("step_level", want.step_level, got.step_level);
                    check_bit("dir_level", want.dir_level, got.dir_level);
                    check_bit("motor_enable", want.motor_enable, got.motor_enable);
                    check_bit("led_open", want.led_open, got.led_open);
                    check_bit("led_close", want.led_close, got.led_close);
                    check_bit("compare_event", want.compare_event, got.compare_event);
                    check_bit("at_min_speed", want.at_min_speed, got.at_min_speed);
                    if (m_tdata[7] !== 1'b0) begin
                        $error("m_tdata fill: expected 0, got %b", m_tdata[7]);
                        fail_count++;
                    end
                    results_checked++;
                    if (want.compare_event)
                        compare_hits++;
                end
            end

            // predict the outputs of each accepted tick
            if (s_tvalid && s_tready) begin
                tick_drive(gsd_item_t'(s_tdata[3:0]), want);
                drive_outputs_q.push_back(want);
            end

            pending_results = drive_outputs_q.size();
        end
    end

endmodule

[test/tb_gate_stepper_drive_with_slowdown_core.sv]
`timescale 1ns / 1ps

module tb_gate_stepper_drive_with_slowdown_core;
    import gsd_pkg::*;

    typedef enum int {EP_START, EP_RUN, EP_STOP} episode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;

    logic hold_off_req;
    int   fail_count;
    int   pending_results;
    int   results_checked;
    int   compare_hits;
    int   ticks_sent;
    int   settings_used;
    int   burst_left;

    gate_stepper_drive_with_slowdown_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    gsd_drive_check drive_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .compare_hits    (compare_hits)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic gsd_item_t tick_item(input logic ob, input logic cb,
                                            input logic eo, input logic ec);
        gsd_item_t it;
        begin
            it.open_button_edge  = ob;
            it.close_button_edge = cb;
            it.end_open_hit      = eo;
            it.end_close_hit     = ec;
            return it;
        end
    endfunction

    // offer one tick item in bursts with random gaps, return after acceptance
    task automatic send_tick(input gsd_item_t it);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0000, it};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            @(negedge clk);
            burst_left--;
            ticks_sent++;
        end
    endtask

    // stop offering and wait until every result item is back
    task automatic drain_results();
        begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            while (pending_results != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= val;
            @(negedge clk);
        end
    endtask

    task automatic load_settings(input logic [15:0] std_p, input logic [15:0] red_p,
                                 input logic [15:0] ramp_p, input logic close_lvl);
        begin
            put_reg(CFG_STD_PERIOD, std_p);
            put_reg(CFG_REDUCED_PERIOD, red_p);
            put_reg(CFG_RAMP_STEP, ramp_p);
            put_reg(CFG_CLOSE_DIR, {15'b0, close_lvl});
            cfg_we <= 1'b0;
            settings_used++;
        end
    endtask

    // gate runs: press a button, travel, maybe slow down, hold an end stop
    task automatic run_traffic(input int n);
        episode_t  stage;
        int        sent;
        int        run_len;
        int        hold_len;
        logic      start_open;
        logic [1:0] stops;
        gsd_item_t it;
        begin
            stage      = EP_START;
            sent       = 0;
            run_len    = 0;
            hold_len   = 0;
            start_open = 1'b0;
            stops      = 2'b01;
            while (sent < n) begin
                it = '0;
                case (stage)
                    EP_START: begin
                        start_open = 1'($urandom_range(0, 1));
                        if ($urandom_range(0, 7) == 0) begin
                            it.open_button_edge  = 1'b1;
                            it.close_button_edge = 1'b1;
                        end
                        else if (start_open) begin
                            it.close_button_edge = 1'b1;
                        end
                        else begin
                            it.open_button_edge = 1'b1;
                        end
                        run_len = $urandom_range(3, 60);
                        stage   = EP_RUN;
                    end
                    EP_RUN: begin
                        run_len--;
                        // other button slows the gate down
                        if ($urandom_range(0, 19) == 0) begin
                            if (start_open)
                                it.open_button_edge = 1'b1;
                            else
                                it.close_button_edge = 1'b1;
                        end
                        // stray noise
                        if ($urandom_range(0, 39) == 0)
                            it = gsd_item_t'(4'($urandom_range(0, 15)));
                        if (run_len <= 0) begin
                            hold_len = $urandom_range(1, 30);
                            stops    = 2'($urandom_range(1, 3));
                            stage    = EP_STOP;
                        end
                    end
                    default: begin
                        it.end_open_hit  = stops[0];
                        it.end_close_hit = stops[1];
                        if ($urandom_range(0, 9) == 0)
                            it.open_button_edge = 1'b1;
                        if ($urandom_range(0, 9) == 0)
                            it.close_button_edge = 1'b1;
                        hold_len--;
                        if (hold_len <= 0)
                            stage = EP_START;
                    end
                endcase
                send_tick(it);
                sent++;
            end
        end
    endtask

    // result side: stall patterns, plus one long hold-off on request
    initial
    begin : result_sink
        int   mode;
        int   left;
        logic hold_off_done;
        m_tready      = 1'b0;
        mode          = 0;
        left          = 0;
        hold_off_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (90) @(negedge clk);
                hold_off_done = 1'b1;
            end
            else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 64);
                end
                left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        hold_off_req  = 1'b0;
        ticks_sent    = 0;
        settings_used = 0;
        burst_left    = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: counter runs up to the reset period, no match yet
        run_traffic(640);
        drain_results();

        // directed: every tick a compare at standard speed
        load_settings(16'd0, 16'd6, 16'd2, 1'b1);
        send_tick(tick_item(1'b0, 1'b0, 1'b0, 1'b0));
        repeat (4) send_tick(tick_item(1'b0, 1'b0, 1'b0, 1'b1));
        repeat (4) send_tick(tick_item(1'b0, 1'b0, 1'b1, 1'b0));
        // start closing, then slow down with the other button
        send_tick(tick_item(1'b1, 1'b0, 1'b0, 1'b0));
        repeat (2) send_tick(tick_item(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_item(1'b0, 1'b1, 1'b0, 1'b0));
        repeat (3) send_tick(tick_item(1'b0, 1'b0, 1'b0, 1'b0));
        // both buttons in one tick
        send_tick(tick_item(1'b1, 1'b1, 1'b0, 1'b0));
        repeat (2) send_tick(tick_item(1'b0, 1'b0, 1'b0, 1'b0));
        // close and open button while still closing, then all bits at once
        send_tick(tick_item(1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(tick_item(1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(tick_item(1'b1, 1'b1, 1'b1, 1'b1));
        repeat (2) send_tick(tick_item(1'b0, 1'b0, 1'b0, 1'b0));
        drain_results();

        // random gate runs under several settings
        load_settings(16'd1, 16'd20, 16'd4, 1'b0);
        hold_off_req <= 1'b1;
        run_traffic(180);
        drain_results();

        load_settings(16'd0, 16'd1, 16'd0, 1'b1);
        run_traffic(120);
        drain_results();

        load_settings(16'd5, 16'd60, 16'd7, 1'b0);
        run_traffic(160);
        drain_results();

        load_settings(16'd2, 16'd12, 16'd1, 1'b1);
        run_traffic(150);
        drain_results();

        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_traffic(100);
        drain_results();

        $display("covered %0d ticks under %0d register settings", ticks_sent,
                 settings_used + 1);
        $display("%0d result items checked, %0d compare matches among them",
                 results_checked, compare_hits);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/gsd_pkg.sv
rtl/core/gsd_cfg_regs.sv
rtl/core/gsd_motion.sv
rtl/core/gate_stepper_drive_with_slowdown_core.sv
test/gsd_drive_check.sv
test/tb_gate_stepper_drive_with_slowdown_core.sv
